FILE: rtl/core/signed_int_to_decimal_ascii_defines.svh
// Assertion macros shared by the signed-integer-to-ASCII RTL.
// No dependencies; included by modules that carry concurrent checks.
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_DEFINES_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_DEFINES_SVH

`ifndef SYNTHESIS

// Check a property on every rising clock edge outside reset.
`define SIDA_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check that a condition never holds outside reset.
`define SIDA_ASSERT_NEVER(label, clk, rst, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`else

`define SIDA_ASSERT(label, clk, rst, prop, msg)
`define SIDA_ASSERT_NEVER(label, clk, rst, expr, msg)

`endif

`endif

FILE: rtl/core/sida_pkg.sv
// Package for the signed-integer-to-ASCII block: states, ASCII codes, sizing.
// No dependencies.
`default_nettype none

package sida_pkg;

  localparam int VALUE_BITS_DEFAULT = 32;

  localparam logic [7:0] ASCII_ZERO  = 8'h30;
  localparam logic [7:0] ASCII_MINUS = 8'h2D;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONVERT,
    ST_SKIP,
    ST_SIGN,
    ST_EMIT
  } state_t;

  // Decimal digit count of 2^(bits-1), the largest magnitude to print.
  function automatic int dec_digits(input int bits);
    logic [63:0] v;
    int          n;
    v = 64'd1 << (bits - 1);
    n = 0;
    for (int i = 0; i < 20; i++) begin
      if (v != 64'd0) begin
        n++;
      end
      v = v / 64'd10;
    end
    return n;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/signed_int_to_decimal_ascii.sv
// Signed integer to decimal ASCII text, top level.
// Depends on sida_pkg and signed_int_to_decimal_ascii_defines.svh.
//
// One transaction on the value channel carries a signed two's complement
// integer of VALUE_BITS bits. The block answers with its decimal text on the
// character channel, one transaction per character, most significant first:
// a leading '-' for negative values, no leading zeros, a single '0' for zero,
// and the most negative value printed in full. last_char marks the final
// character of each number. Conversion is double dabble: one magnitude bit
// is shifted into a BCD register per cycle through one shared add-3
// correction and shift unit. An item passes through an accept step, one
// conversion step per magnitude bit, leading-zero skipping, an optional
// minus sign and one step per emitted character; the sign and character
// steps wait while the character channel stalls. NDIG is the digit count
// of 2^(VALUE_BITS-1), the largest magnitude to print.
// value_ready is high only while idle; a finished character sits in an
// output register, so a new value is taken while the last one waits.
`default_nettype none

`include "signed_int_to_decimal_ascii_defines.svh"

module signed_int_to_decimal_ascii #(
  parameter int VALUE_BITS = sida_pkg::VALUE_BITS_DEFAULT
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         value_valid,
  output logic                              value_ready,
  input  wire logic signed [VALUE_BITS-1:0] value,
  output logic                              char_valid,
  input  wire logic                         char_ready,
  output logic [7:0]                        character,
  output logic                              last_char
);

  localparam int NDIG = sida_pkg::dec_digits(VALUE_BITS);
  localparam int BCDW = NDIG * 4;
  localparam int CW   = $clog2(VALUE_BITS + 1);
  localparam int DW   = $clog2(NDIG + 1);

  sida_pkg::state_t state, state_next;

  logic [VALUE_BITS-1:0] bin, bin_next;     // magnitude, shifted out MSB first
  logic [BCDW-1:0]       bcd, bcd_next;     // BCD digits, top digit emitted next
  logic [CW-1:0]         cnt, cnt_next;     // conversion bits still to go
  logic [DW-1:0]         dig, dig_next;     // digits still in the BCD register
  logic                  neg, neg_next;
  logic                  char_valid_next;
  logic [7:0]            character_next;
  logic                  last_char_next;

  logic [BCDW-1:0]       adj;               // add-3 corrected digits
  logic [3:0]            top;
  logic                  out_free;          // output register may take a char
  logic [VALUE_BITS-1:0] raw;

  assign raw      = value;
  assign top      = bcd[BCDW-1 -: 4];
  assign out_free = !char_valid || char_ready;

  // Correct every digit that would overflow on the next doubling.
  always_comb begin
    for (int d = 0; d < NDIG; d++) begin
      if (bcd[d*4 +: 4] >= 4'd5) begin
        adj[d*4 +: 4] = bcd[d*4 +: 4] + 4'd3;
      end else begin
        adj[d*4 +: 4] = bcd[d*4 +: 4];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= sida_pkg::ST_IDLE;
      char_valid <= 1'b0;
    end else begin
      state      <= state_next;
      char_valid <= char_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    bin       <= bin_next;
    bcd       <= bcd_next;
    cnt       <= cnt_next;
    dig       <= dig_next;
    neg       <= neg_next;
    character <= character_next;
    last_char <= last_char_next;
  end

  always_comb begin
    state_next      = state;
    bin_next        = bin;
    bcd_next        = bcd;
    cnt_next        = cnt;
    dig_next        = dig;
    neg_next        = neg;
    character_next  = character;
    last_char_next  = last_char;
    value_ready     = 1'b0;
    // Drop the held character once the consumer takes it.
    char_valid_next = char_valid && !char_ready;

    case (state)
      sida_pkg::ST_IDLE: begin
        value_ready = 1'b1;
        if (value_valid) begin
          neg_next   = raw[VALUE_BITS-1];
          // Negate in VALUE_BITS bits; the most negative value maps to itself,
          // which read unsigned is exactly its magnitude.
          bin_next   = raw[VALUE_BITS-1] ? (~raw + {{(VALUE_BITS-1){1'b0}}, 1'b1}) : raw;
          bcd_next   = '0;
          cnt_next   = CW'(VALUE_BITS);
          state_next = sida_pkg::ST_CONVERT;
        end
      end

      sida_pkg::ST_CONVERT: begin
        // Shift one magnitude bit into the corrected BCD register.
        bcd_next = {adj[BCDW-2:0], bin[VALUE_BITS-1]};
        bin_next = bin << 1;
        cnt_next = cnt - CW'(1);
        if (cnt == CW'(1)) begin
          dig_next   = DW'(NDIG);
          state_next = sida_pkg::ST_SKIP;
        end
      end

      sida_pkg::ST_SKIP: begin
        // Drop leading zeros, but always keep the last digit.
        if (top == 4'd0 && dig != DW'(1)) begin
          bcd_next = bcd << 4;
          dig_next = dig - DW'(1);
        end else if (neg) begin
          state_next = sida_pkg::ST_SIGN;
        end else begin
          state_next = sida_pkg::ST_EMIT;
        end
      end

      sida_pkg::ST_SIGN: begin
        if (out_free) begin
          char_valid_next = 1'b1;
          character_next  = sida_pkg::ASCII_MINUS;
          last_char_next  = 1'b0;
          state_next      = sida_pkg::ST_EMIT;
        end
      end

      sida_pkg::ST_EMIT: begin
        if (out_free) begin
          char_valid_next = 1'b1;
          character_next  = sida_pkg::ASCII_ZERO + {4'd0, top};
          last_char_next  = (dig == DW'(1));
          bcd_next        = bcd << 4;
          dig_next        = dig - DW'(1);
          if (dig == DW'(1)) begin
            state_next = sida_pkg::ST_IDLE;
          end
        end
      end

      default: begin
        state_next = sida_pkg::ST_IDLE;
      end
    endcase
  end

  // Checks on the sequencer and the character stream.
  `SIDA_ASSERT(a_accept_starts, clk, rst, (value_valid && value_ready) |=> (state == sida_pkg::ST_CONVERT), "accepted value did not start conversion")
  `SIDA_ASSERT_NEVER(a_cnt_live, clk, rst, (state == sida_pkg::ST_CONVERT) && (cnt == CW'(0)), "conversion running with no bits left")
  `SIDA_ASSERT_NEVER(a_dig_live, clk, rst, (state == sida_pkg::ST_SKIP || state == sida_pkg::ST_EMIT) && (dig == DW'(0)), "digit stage with no digits left")
  `SIDA_ASSERT(a_char_code, clk, rst, char_valid |-> (character == sida_pkg::ASCII_MINUS || (character >= 8'h30 && character <= 8'h39)), "character is neither minus nor digit")
  `SIDA_ASSERT(a_minus_not_last, clk, rst, (char_valid && character == sida_pkg::ASCII_MINUS) |-> !last_char, "minus sign flagged as last character")

endmodule

`default_nettype wire
